// ----- design/haze_model_pixel_engine_macros.svh -----
// Assertion helpers shared by the haze model pixel engine RTL.
`ifndef HAZE_MODEL_PIXEL_ENGINE_MACROS_SVH
`define HAZE_MODEL_PIXEL_ENGINE_MACROS_SVH
`ifndef SYNTH
`define HZM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hzm: same-cycle check failed");
`define HZM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hzm: next-cycle check failed");
`else
`define HZM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HZM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/hzm_pkg.sv -----
package hzm_pkg;

  localparam int CHANNEL_BITS    = 12;
  localparam int TRANS_BITS      = CHANNEL_BITS + 1;
  localparam int PROD_BITS       = 2 * CHANNEL_BITS + 3;
  localparam int NUM_CH          = 3;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = (CHANNEL_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int PIPE_STAGES     = DIV_STAGES + 2;

  localparam int IN_BITS       = NUM_CH * CHANNEL_BITS + TRANS_BITS;
  localparam int IN_DATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS      = NUM_CH * CHANNEL_BITS;
  localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int REG_COUNT = 5;
  localparam int IDX_BITS  = $clog2(REG_COUNT);
  localparam int ADDR_BITS = IDX_BITS + 2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [TRANS_BITS-1:0]   trans_t;

  localparam trans_t TRANS_ONE       = trans_t'(1) << CHANNEL_BITS;
  localparam chan_t  PIX_MAX         = '1;
  localparam trans_t MIN_TRANS_RESET = trans_t'(410);
  localparam logic [PROD_BITS-1:0] AUG_HALF = PROD_BITS'(1) << (CHANNEL_BITS - 1);

  typedef enum logic [IDX_BITS-1:0] {
    REG_DIRECTION,
    REG_LIGHT_RED,
    REG_LIGHT_GREEN,
    REG_LIGHT_BLUE,
    REG_MIN_TRANS
  } reg_idx_t;

  typedef enum logic {
    DIR_AUGMENT = 1'b0,
    DIR_RECOVER = 1'b1
  } dir_t;

  // First stage: clamped transmission, divisor and channel differences.
  typedef struct packed {
    dir_t                                dir;
    trans_t                              t;
    trans_t                              tb;
    logic [NUM_CH-1:0]                   neg;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] mag;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] lit;
    logic [NUM_CH-1:0][TRANS_BITS-1:0]   diff;
  } front_stage_t;

  // Divider stages; the augment product and result ride along.
  typedef struct packed {
    dir_t                                dir;
    trans_t                              tb;
    logic [NUM_CH-1:0]                   neg;
    logic [NUM_CH-1:0]                   ovf;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] lit;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] rem;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] quo;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] aug;
    logic [NUM_CH-1:0][PROD_BITS-1:0]    prod;
  } div_stage_t;

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [CHANNEL_BITS:0] div_step(input chan_t rem, input logic dbit,
                                                     input trans_t den);
    trans_t part;
    trans_t diff;
    part = {rem, dbit};
    diff = part - den;
    if (part >= den) begin
      return {1'b1, diff[CHANNEL_BITS-1:0]};
    end
    return {1'b0, part[CHANNEL_BITS-1:0]};
  endfunction

endpackage

// ----- design/haze_model_pixel_engine.sv -----
// Haze model pixel engine. Each input beat carries one RGB pixel and its transmission t
// (4096 means 1.0); each output beat carries the three result channels and a flag that
// is set when any channel saturated. With direction 0 the block adds haze,
// t*J + (1 - t)*A; with direction 1 it removes it, (I - A) / max(t, t0) + A, rounded to
// nearest and saturated to 0..4095. The block takes one pixel per clock while the output
// is not stalled; the pipeline's length is set by the division, which runs as a restoring
// divider with three quotient bits per pipeline stage over four stages, between an
// input stage and an output register. Each stage holds its beat only while the stage
// after it is full, so bubbles close up and the input stalls only when all six stages
// hold a pixel. Registers sit at byte addresses 0, 4, 8, 12 and 16: direction,
// light_red, light_green, light_blue and min_transmission; they should be written
// only while the pipeline is empty.
`include "haze_model_pixel_engine_macros.svh"

module haze_model_pixel_engine import hzm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // pix_red, pix_green, pix_blue, trans_value, zero fill
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // res_red, res_green, res_blue, zero fill
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // clipped
  output logic                     m_tuser
);

  localparam int LAST = PIPE_STAGES - 1;

  dir_t                                direction;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] light;
  trans_t                              min_trans;
  trans_t                              t0_eff;
  logic                                cfg_wr;
  reg_idx_t                            cfg_idx;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] load;

  front_stage_t front;
  front_stage_t front_next;
  div_stage_t   dv [DIV_STAGES];

  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] out_res;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] out_res_next;
  logic                                out_clip;
  logic                                out_clip_next;
  dir_t                                out_dir;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_RECOVER;
      light     <= {NUM_CH{PIX_MAX}};
      min_trans <= MIN_TRANS_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIRECTION:   direction <= dir_t'(pwdata[0]);
        REG_LIGHT_RED:   light[0]  <= pwdata[CHANNEL_BITS-1:0];
        REG_LIGHT_GREEN: light[1]  <= pwdata[CHANNEL_BITS-1:0];
        REG_LIGHT_BLUE:  light[2]  <= pwdata[CHANNEL_BITS-1:0];
        REG_MIN_TRANS:   min_trans <= pwdata[TRANS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIRECTION:   prdata = 32'(direction);
      REG_LIGHT_RED:   prdata = 32'(light[0]);
      REG_LIGHT_GREEN: prdata = 32'(light[1]);
      REG_LIGHT_BLUE:  prdata = 32'(light[2]);
      REG_MIN_TRANS:   prdata = 32'(min_trans);
      default:         prdata = '0;
    endcase
  end

  // A bound of zero acts as the smallest step (1/4096), a bound above one acts as one.
  always_comb begin
    if (min_trans == '0) begin
      t0_eff = trans_t'(1);
    end else if (min_trans > TRANS_ONE) begin
      t0_eff = TRANS_ONE;
    end else begin
      t0_eff = min_trans;
    end
  end

  // Pipeline flow control: a stage loads when it is empty or the next one loads.
  always_comb begin
    load[LAST] = !vld[LAST] || m_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign s_tready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Front stage.
  always_comb begin
    trans_t t_in;
    trans_t t_c;
    trans_t d;
    trans_t d_neg;
    t_in = s_tdata[NUM_CH*CHANNEL_BITS +: TRANS_BITS];
    t_c  = (t_in > TRANS_ONE) ? TRANS_ONE : t_in;
    front_next.dir = direction;
    front_next.t   = t_c;
    front_next.tb  = (t_c > t0_eff) ? t_c : t0_eff;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      d     = {1'b0, s_tdata[ch*CHANNEL_BITS +: CHANNEL_BITS]} - {1'b0, light[ch]};
      d_neg = trans_t'(0) - d;
      front_next.neg[ch]  = d[CHANNEL_BITS];
      front_next.mag[ch]  = d[CHANNEL_BITS] ? d_neg[CHANNEL_BITS-1:0] : d[CHANNEL_BITS-1:0];
      front_next.lit[ch]  = light[ch];
      front_next.diff[ch] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      front <= front_next;
    end
  end

  // Divider stages. The dividend is |I - A| * 4096 + tb/2, so its upper half is the
  // magnitude and its lower half is tb shifted down by one.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    div_stage_t nxt;

    always_comb begin
      int                    k;
      logic [CHANNEL_BITS:0] st;
      logic signed [PROD_BITS-1:0] psum;
      logic signed [PROD_BITS-1:0] rounded;
      if (s == 0) begin
        nxt.dir = front.dir;
        nxt.tb  = front.tb;
        nxt.neg = front.neg;
        nxt.lit = front.lit;
        nxt.aug = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          nxt.prod[ch] = PROD_BITS'($signed({1'b0, front.t})) *
                         PROD_BITS'($signed(front.diff[ch]));
          // A quotient of 4096 or more always saturates.
          nxt.ovf[ch]  = {1'b0, front.mag[ch]} >= front.tb;
          nxt.rem[ch]  = front.mag[ch];
          nxt.quo[ch]  = '0;
        end
      end else begin
        nxt = dv[(s == 0) ? 0 : s - 1];
      end
      if (s == 1) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          psum        = $signed(dv[0].prod[ch] + AUG_HALF);
          rounded     = psum >>> CHANNEL_BITS;
          nxt.aug[ch] = rounded[CHANNEL_BITS-1:0] + dv[0].lit[ch];
        end
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          k = CHANNEL_BITS - 1 - (s * STEPS_PER_STAGE + j);
          if (k >= 0) begin
            st          = div_step(nxt.rem[ch], nxt.tb[k+1], nxt.tb);
            nxt.rem[ch] = st[CHANNEL_BITS-1:0];
            nxt.quo[ch] = {nxt.quo[ch][CHANNEL_BITS-2:0], st[CHANNEL_BITS]};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load[s+1]) begin
        dv[s] <= nxt;
      end
    end
  end

  // Output stage: add the light back, saturate, pick the mode.
  always_comb begin
    logic [CHANNEL_BITS:0] sum;
    logic [CHANNEL_BITS:0] dif;
    div_stage_t            src;
    src           = dv[DIV_STAGES-1];
    out_clip_next = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum = {1'b0, src.lit[ch]} + {1'b0, src.quo[ch]};
      dif = {1'b0, src.lit[ch]} - {1'b0, src.quo[ch]};
      if (src.dir == DIR_AUGMENT) begin
        out_res_next[ch] = src.aug[ch];
      end else if (src.ovf[ch]) begin
        out_res_next[ch] = src.neg[ch] ? chan_t'(0) : PIX_MAX;
        out_clip_next    = 1'b1;
      end else if (src.neg[ch]) begin
        out_res_next[ch] = dif[CHANNEL_BITS] ? chan_t'(0) : dif[CHANNEL_BITS-1:0];
        out_clip_next    = out_clip_next || dif[CHANNEL_BITS];
      end else begin
        out_res_next[ch] = sum[CHANNEL_BITS] ? PIX_MAX : sum[CHANNEL_BITS-1:0];
        out_clip_next    = out_clip_next || sum[CHANNEL_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[LAST]) begin
      out_res  <= out_res_next;
      out_clip <= out_clip_next;
      out_dir  <= dv[DIV_STAGES-1].dir;
    end
  end

  assign m_tvalid = vld[LAST];
  assign m_tdata  = OUT_DATA_BITS'(out_res);
  assign m_tuser  = out_clip;

  // Adding haze never leaves the range.
  `HZM_ASSERT_IMP(a_augment_never_clips, clk, rst, m_tvalid && out_dir == DIR_AUGMENT, !out_clip)
  // The input only stalls when every stage holds a pixel.
  `HZM_ASSERT_IMP(a_stall_only_when_full, clk, rst, !s_tready, &vld)
  // An accepted beat lands in the front stage.
  `HZM_ASSERT_NXT(a_accept_fills_front, clk, rst, s_tvalid && s_tready, vld[0])

endmodule
